/* sv/assert_macros.svh */
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while in reset
`define ASSERT_CLK(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion name failed");

// clocked check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion name failed");

`endif

/* sv/dxt_pkg.sv */
package dxt_pkg;

  localparam int NumCols = 4;
  localparam int NumRows = 4;
  localparam int RowW = $clog2(NumRows);
  localparam logic [RowW-1:0] LastRow = RowW'(NumRows - 1);

  localparam logic FMT_DXT1 = 1'b0;
  localparam logic FMT_DXT5 = 1'b1;

  typedef logic [7:0] chan_t;

  typedef struct packed {
    chan_t [2:0]       e0;
    chan_t [2:0]       e1;
    logic              four;
    logic              fmt;
    logic              a_gt;
    chan_t             a0;
    chan_t             a1;
    logic [5:0][10:0]  asum;
    logic [31:0]       cidx;
    logic [47:0]       aidx;
  } s1_t;

  typedef struct packed {
    logic [3:0][31:0]  cpal;
    chan_t [7:0]       apal;
    logic              fmt;
    logic [31:0]       cidx;
    logic [47:0]       aidx;
  } s2_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pal_ctrl_t;

  // v * 255 / 31 via reciprocal
  function automatic chan_t widen5(input logic [4:0] v);
    logic [26:0] p;
    begin
      p = 27'(v) * 27'd255 * 27'd8457;
      return p[25:18];
    end
  endfunction

  // v * 255 / 63 via reciprocal
  function automatic chan_t widen6(input logic [5:0] v);
    logic [29:0] p;
    begin
      p = 30'(v) * 30'd255 * 30'd16645;
      return p[27:20];
    end
  endfunction

  function automatic chan_t div3(input logic [9:0] x);
    logic [20:0] p;
    begin
      p = 21'(x) * 21'd683;
      return p[18:11];
    end
  endfunction

  function automatic chan_t div5(input logic [10:0] x);
    logic [23:0] p;
    begin
      p = 24'(x) * 24'd3277;
      return p[21:14];
    end
  endfunction

  function automatic chan_t div7(input logic [10:0] x);
    logic [23:0] p;
    begin
      p = 24'(x) * 24'd2341;
      return p[21:14];
    end
  endfunction

endpackage

/* sv/dxt_palette.sv */
module dxt_palette (
  input  logic              clk,
  input  dxt_pkg::pal_ctrl_t ctrl,
  input  logic              fmt,
  input  logic [63:0]       color_block,
  input  logic [63:0]       alpha_block,
  output dxt_pkg::s2_t      s2
);
  import dxt_pkg::*;

  s1_t s1, s1_next;
  s2_t s2_next;
  logic [15:0] c0, c1;
  logic [9:0]  sum_a [3];
  logic [9:0]  sum_b [3];
  logic [8:0]  sum_h [3];
  chan_t       mid_a [3];
  chan_t       mid_b [3];

  // stage 1: endpoint widening and alpha weighted sums
  always_comb begin
    c0 = color_block[15:0];
    c1 = color_block[31:16];
    s1_next.e0[0] = widen5(c0[15:11]);
    s1_next.e0[1] = widen6(c0[10:5]);
    s1_next.e0[2] = widen5(c0[4:0]);
    s1_next.e1[0] = widen5(c1[15:11]);
    s1_next.e1[1] = widen6(c1[10:5]);
    s1_next.e1[2] = widen5(c1[4:0]);
    s1_next.four = (fmt == FMT_DXT5) || (c0 > c1);
    s1_next.fmt = fmt;
    s1_next.a0 = alpha_block[7:0];
    s1_next.a1 = alpha_block[15:8];
    s1_next.a_gt = alpha_block[7:0] > alpha_block[15:8];
    for (int k = 1; k <= 6; k++) begin
      if (s1_next.a_gt) begin
        s1_next.asum[k-1] = 11'((7 - k) * int'(s1_next.a0) + k * int'(s1_next.a1));
      end else if (k <= 4) begin
        s1_next.asum[k-1] = 11'((5 - k) * int'(s1_next.a0) + k * int'(s1_next.a1));
      end else begin
        s1_next.asum[k-1] = '0;
      end
    end
    s1_next.cidx = color_block[63:32];
    s1_next.aidx = alpha_block[63:16];
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_load) begin
      s1 <= s1_next;
    end
  end

  // stage 2: interpolated palette entries
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_a[ch] = {1'b0, s1.e0[ch], 1'b0} + 10'(s1.e1[ch]);
      sum_b[ch] = 10'(s1.e0[ch]) + {1'b0, s1.e1[ch], 1'b0};
      sum_h[ch] = 9'(s1.e0[ch]) + 9'(s1.e1[ch]);
      mid_a[ch] = div3(sum_a[ch]);
      mid_b[ch] = div3(sum_b[ch]);
    end
    s2_next.cpal[0] = {8'hFF, s1.e0[2], s1.e0[1], s1.e0[0]};
    s2_next.cpal[1] = {8'hFF, s1.e1[2], s1.e1[1], s1.e1[0]};
    if (s1.four) begin
      s2_next.cpal[2] = {8'hFF, mid_a[2], mid_a[1], mid_a[0]};
      s2_next.cpal[3] = {8'hFF, mid_b[2], mid_b[1], mid_b[0]};
    end else begin
      s2_next.cpal[2] = {8'hFF, sum_h[2][8:1], sum_h[1][8:1], sum_h[0][8:1]};
      s2_next.cpal[3] = '0;
    end
    s2_next.apal[0] = s1.a0;
    s2_next.apal[1] = s1.a1;
    for (int k = 1; k <= 6; k++) begin
      if (s1.a_gt) begin
        s2_next.apal[k+1] = div7(s1.asum[k-1]);
      end else if (k <= 4) begin
        s2_next.apal[k+1] = div5(s1.asum[k-1]);
      end else if (k == 5) begin
        s2_next.apal[k+1] = 8'h00;
      end else begin
        s2_next.apal[k+1] = 8'hFF;
      end
    end
    s2_next.fmt = s1.fmt;
    s2_next.cidx = s1.cidx;
    s2_next.aidx = s1.aidx;
  end

  always_ff @(posedge clk) begin
    if (ctrl.s2_load) begin
      s2 <= s2_next;
    end
  end

endmodule

/* sv/dxt_lane.sv */
module dxt_lane (
  input  logic [3:0][31:0]     cpal,
  input  dxt_pkg::chan_t [7:0] apal,
  input  logic                 fmt,
  input  logic [1:0]           ci,
  input  logic [2:0]           ai,
  output logic [31:0]          px
);
  import dxt_pkg::*;

  logic [31:0] color;
  chan_t       alpha;

  always_comb begin
    unique case (ci)
      2'd0: color = cpal[0];
      2'd1: color = cpal[1];
      2'd2: color = cpal[2];
      2'd3: color = cpal[3];
      default: color = cpal[0];
    endcase
    alpha = apal[ai];
    if (fmt == FMT_DXT5) begin
      px = {alpha, color[23:0]};
    end else begin
      px = color;
    end
  end

endmodule

/* sv/dxt_block_decompressor.sv */
// DXT1/DXT5 (BC1/BC3) 4x4 block decoder. Each request carries one 64-bit color
// block and one 64-bit alpha block (the latter ignored when block_format is 0,
// DXT1) and yields four output requests, rows 0 to 3, each with four RGBA8888
// pixels (red in the low byte) and last_row set on row 3. The row sequencer
// drives one row a cycle, while the output is not stalled, through four column
// lanes into the output register, and a new block is taken while the previous
// one is still being emitted. A block passes through the endpoint widening
// register (loaded at the edge that accepts it), the palette interpolation
// register and then the output register. block_format is written through
// cfg_valid/cfg_data and applies to blocks accepted afterwards; the user must
// write it only while no block is in flight, as the block does not enforce this.
module dxt_block_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] color_block,
  input  logic [63:0] alpha_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_col0,
  output logic [31:0] pixel_col1,
  output logic [31:0] pixel_col2,
  output logic [31:0] pixel_col3,
  output logic [1:0]  row_number,
  output logic        last_row
);
  import dxt_pkg::*;

  logic            block_format;
  logic            s1_valid, s1_valid_next;
  logic            s2_valid, s2_valid_next;
  logic            out_valid_next;
  logic [RowW-1:0] row;
  logic            out_load, emit, s2_done;
  pal_ctrl_t       ctrl;
  s2_t             s2;
  logic [7:0]      row_cidx;
  logic [11:0]     row_aidx;
  logic [31:0]     lane_px [NumCols];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      block_format <= cfg_data;
    end
  end

  // pipeline control
  always_comb begin
    out_load = !out_valid || !out_stall;
    emit = s2_valid && out_load;
    s2_done = emit && (row == LastRow);
    ctrl.s2_load = s1_valid && (!s2_valid || s2_done);
    in_stall = s1_valid && !ctrl.s2_load;
    ctrl.s1_load = in_valid && !in_stall;
    s1_valid_next = ctrl.s1_load || (s1_valid && !ctrl.s2_load);
    s2_valid_next = ctrl.s2_load || (s2_valid && !s2_done);
    out_valid_next = out_load ? s2_valid : out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
      row <= '0;
    end else begin
      s1_valid <= s1_valid_next;
      s2_valid <= s2_valid_next;
      out_valid <= out_valid_next;
      if (emit) begin
        row <= row + 1'b1;
      end
    end
  end

  dxt_palette u_palette (
    .clk         (clk),
    .ctrl        (ctrl),
    .fmt         (block_format),
    .color_block (color_block),
    .alpha_block (alpha_block),
    .s2          (s2)
  );

  assign row_cidx = s2.cidx[{row, 3'b000} +: 8];
  assign row_aidx = s2.aidx[6'(row) * 6'd12 +: 12];

  for (genvar c = 0; c < NumCols; c++) begin : g_lane
    dxt_lane u_lane (
      .cpal (s2.cpal),
      .apal (s2.apal),
      .fmt  (s2.fmt),
      .ci   (row_cidx[2*c +: 2]),
      .ai   (row_aidx[3*c +: 3]),
      .px   (lane_px[c])
    );
  end

  // row merge into the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_col0 <= lane_px[0];
      pixel_col1 <= lane_px[1];
      pixel_col2 <= lane_px[2];
      pixel_col3 <= lane_px[3];
      row_number <= row;
      last_row <= (row == LastRow);
    end
  end

endmodule

/* sv/dxt_checker.sv */
`include "assert_macros.svh"

module dxt_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] pixel_col0,
  input logic [31:0] pixel_col1,
  input logic [31:0] pixel_col2,
  input logic [31:0] pixel_col3,
  input logic [1:0]  row_number,
  input logic        last_row
);
  import dxt_pkg::*;

  `ASSERT_CLK(a_stall_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(pixel_col0) && $stable(pixel_col1) && $stable(pixel_col2) && $stable(pixel_col3) && $stable(row_number))
  `ASSERT_CLK(a_last_flag, clk, rst, out_valid |-> (last_row == (row_number == LastRow)))
  `ASSERT_CLK(a_rows_in_burst, clk, rst, out_valid && !out_stall && !last_row |=> out_valid && (row_number == $past(row_number) + 2'd1))
  `ASSERT_CLK(a_new_block_row0, clk, rst, out_valid && !out_stall && last_row |=> !out_valid || (row_number == '0))
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind dxt_block_decompressor dxt_checker u_dxt_checker (.*);

/* dv/dxt_block_decompressor_test.sv */
module dxt_block_decompressor_test;
  import dxt_pkg::FMT_DXT1;
  import dxt_pkg::FMT_DXT5;

  typedef struct packed {
    logic [3:0][31:0] px;
    logic [1:0]       row;
    logic             last;
  } pixel_row_t;

  // alpha indices 0..7 repeated over the sixteen pixels
  localparam logic [47:0] AlphaRamp = 48'hFAC688FAC688;
  // every alpha index set to 6
  localparam logic [47:0] AlphaSix = 48'hDB6DB6DB6DB6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] color_block = '0;
  logic [63:0] alpha_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pixel_col0;
  logic [31:0] pixel_col1;
  logic [31:0] pixel_col2;
  logic [31:0] pixel_col3;
  logic [1:0]  row_number;
  logic        last_row;

  logic       cur_format = FMT_DXT1;
  bit         tx_idle = 1'b1;
  bit         rx_idle = 1'b1;
  int         rx_gap = 0;
  int         next_gap;
  int         hold_len = 0;
  int         hold_left = 0;
  int         mismatches = 0;
  pixel_row_t pending_rows[$];
  pixel_row_t got;
  pixel_row_t want;

  dxt_block_decompressor u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .color_block(color_block),
    .alpha_block(alpha_block),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_col0 (pixel_col0),
    .pixel_col1 (pixel_col1),
    .pixel_col2 (pixel_col2),
    .pixel_col3 (pixel_col3),
    .row_number (row_number),
    .last_row   (last_row)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int chan5(input logic [4:0] v);
    return int'(v) * 255 / 31;
  endfunction

  function automatic int chan6(input logic [5:0] v);
    return int'(v) * 255 / 63;
  endfunction

  function automatic logic [31:0] rgba(input int r, input int g, input int b, input int a);
    return {a[7:0], b[7:0], g[7:0], r[7:0]};
  endfunction

  // expected four rows of one block, appended to pending_rows
  function automatic void decode_block(input logic [63:0] cb, input logic [63:0] ab,
                                       input logic fmt);
    logic [15:0] c0;
    logic [15:0] c1;
    int          e0[3];
    int          e1[3];
    logic [31:0] cpal[4];
    int          apal[8];
    logic        four;
    logic [31:0] px;
    pixel_row_t  r;
    c0 = cb[15:0];
    c1 = cb[31:16];
    four = (fmt == FMT_DXT5) || (c0 > c1);
    e0[0] = chan5(c0[15:11]);
    e0[1] = chan6(c0[10:5]);
    e0[2] = chan5(c0[4:0]);
    e1[0] = chan5(c1[15:11]);
    e1[1] = chan6(c1[10:5]);
    e1[2] = chan5(c1[4:0]);
    cpal[0] = rgba(e0[0], e0[1], e0[2], 255);
    cpal[1] = rgba(e1[0], e1[1], e1[2], 255);
    if (four) begin
      cpal[2] = rgba((2 * e0[0] + e1[0]) / 3, (2 * e0[1] + e1[1]) / 3,
                     (2 * e0[2] + e1[2]) / 3, 255);
      cpal[3] = rgba((e0[0] + 2 * e1[0]) / 3, (e0[1] + 2 * e1[1]) / 3,
                     (e0[2] + 2 * e1[2]) / 3, 255);
    end else begin
      cpal[2] = rgba((e0[0] + e1[0]) / 2, (e0[1] + e1[1]) / 2, (e0[2] + e1[2]) / 2, 255);
      cpal[3] = '0;
    end
    apal[0] = int'(ab[7:0]);
    apal[1] = int'(ab[15:8]);
    if (apal[0] > apal[1]) begin
      for (int k = 1; k <= 6; k++) apal[k + 1] = ((7 - k) * apal[0] + k * apal[1]) / 7;
    end else begin
      for (int k = 1; k <= 4; k++) apal[k + 1] = ((5 - k) * apal[0] + k * apal[1]) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        px = cpal[cb[32 + 2 * (4 * row + col) +: 2]];
        if (fmt == FMT_DXT5) px[31:24] = 8'(apal[ab[16 + 3 * (4 * row + col) +: 3]]);
        r.px[col] = px;
      end
      r.row = 2'(row);
      r.last = (row == 3);
      pending_rows.push_back(r);
    end
  endfunction

  task automatic send_block(input logic [63:0] cb, input logic [63:0] ab);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    color_block <= cb;
    alpha_block <= ab;
    do @(posedge clk); while (!(in_valid && !in_stall));
    decode_block(cb, ab, cur_format);
  endtask

  task automatic drain_rows();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_format(input logic fmt);
    drain_rows();
    cfg_data <= fmt;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    cur_format = fmt;
  endtask

  task automatic send_random(input int count);
    logic [63:0] cb;
    logic [63:0] ab;
    repeat (count) begin
      cb = {$urandom, $urandom};
      ab = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) cb[31:16] = cb[15:0];
      if ($urandom_range(0, 7) == 0) ab[15:8] = ab[7:0];
      send_block(cb, ab);
    end
  endtask

  // format left at its reset value
  task automatic test_dxt1_directed();
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    send_block(64'h0, 64'h0);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, 64'h0123_4567_89AB_CDEF);
    send_block({32'hFFFFFFFF, 16'h7BEF, 16'h7BEF}, 64'h0);
    send_block({32'h1B1B1B1B, 16'h07E0, 16'hF800}, {$urandom, $urandom});
    send_block({32'h4E4E4E4E, 16'hF800, 16'h001F}, {$urandom, $urandom});
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block({32'hAAAA5555, 16'h8410, 16'h8411}, 64'h0);
  endtask

  task automatic test_dxt5_directed();
    write_format(FMT_DXT5);
    send_block({32'hE4E4E4E4, 16'h0000, 16'hFFFF}, {AlphaRamp, 8'h00, 8'hFF});
    send_block({32'hE4E4E4E4, 16'hFFFF, 16'h0000}, {AlphaRamp, 8'hFF, 8'h00});
    send_block({32'h1B1B1B1B, 16'h1234, 16'h1234}, {AlphaRamp, 8'h80, 8'h80});
    send_block({32'h4E4E4E4E, 16'hF800, 16'h001F}, {AlphaRamp, 8'hFE, 8'hFF});
    send_block({32'hE4E4E4E4, 16'h07E0, 16'hF800}, {AlphaRamp, 8'h00, 8'h01});
    send_block({32'hFFFFFFFF, 16'h0000, 16'h0000}, {48'hFFFF_FFFF_FFFF, 8'h20, 8'h10});
    send_block({32'h00000000, 16'hFFFF, 16'hFFFF}, {AlphaSix, 8'h20, 8'h30});
    send_block({32'h00000000, 16'h0000, 16'h0000}, {AlphaSix, 8'h40, 8'h10});
    send_block(64'h0, 64'h0);
    send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_formats();
    tx_idle = 1'b1;
    rx_idle <= 1'b1;
    write_format(FMT_DXT1);
    send_random(35);
    write_format(FMT_DXT5);
    send_random(35);
    write_format(FMT_DXT1);
    send_random(35);
    write_format(FMT_DXT5);
    send_random(35);
  endtask

  task automatic test_back_to_back();
    tx_idle = 1'b0;
    rx_idle <= 1'b0;
    send_random(25);
  endtask

  // receiver holds off while blocks keep coming, so the input stalls
  task automatic test_output_hold();
    write_format(FMT_DXT1);
    tx_idle = 1'b0;
    rx_idle <= 1'b1;
    hold_len <= 100;
    @(posedge clk);
    hold_len <= 0;
    send_random(20);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_len != 0) begin
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_gap <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        next_gap = rx_idle ? $urandom_range(0, 3) : 0;
      end else if (rx_gap != 0) begin
        next_gap = rx_gap - 1;
      end else begin
        next_gap = 0;
      end
      rx_gap <= next_gap;
      out_stall <= (next_gap != 0) || (hold_left > 1);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got.px = {pixel_col3, pixel_col2, pixel_col1, pixel_col0};
      got.row = row_number;
      got.last = last_row;
      if (pending_rows.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected row: %h %h %h %h row %0d last %0b",
                   got.px[0], got.px[1], got.px[2], got.px[3], got.row, got.last);
        end
        mismatches++;
      end else begin
        want = pending_rows.pop_front();
        if (got.px[0] !== want.px[0] || got.px[1] !== want.px[1] ||
            got.px[2] !== want.px[2] || got.px[3] !== want.px[3] ||
            got.row !== want.row || got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("row mismatch: expected %h %h %h %h row %0d last %0b",
                     want.px[0], want.px[1], want.px[2], want.px[3], want.row, want.last);
            $display("              got      %h %h %h %h row %0d last %0b",
                     got.px[0], got.px[1], got.px[2], got.px[3], got.row, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_dxt1_directed();
    test_dxt5_directed();
    test_random_formats();
    test_back_to_back();
    test_output_hold();
    drain_rows();
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("FAIL");
    $finish;
  end

endmodule
